/* design/nlct_pkg.sv */
// Shared types and constants of the nearest light cull table.
`default_nettype none

package nlct_pkg;

  localparam int CNT_W   = 7;
  localparam int SQ_W    = 41;
  localparam int ACC_W   = 42;
  localparam int KEY_W   = 43;
  localparam int ROOT_W  = 28;
  localparam int SRC_W   = 56;
  localparam int NUMER_W = 37;
  localparam int REM_W   = 32;

  localparam logic [5:0] SQRT_STEPS = 6'd28;
  localparam logic [5:0] DIV_STEPS  = 6'd37;

  localparam logic [2:0] CMD_POINT  = 3'd0;
  localparam logic [2:0] CMD_DIR    = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_CULL   = 3'd4;
  localparam logic [2:0] CMD_SUN    = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // default sun direction 0.3, 0.5, 0.8 in Q12.8
  localparam logic signed [19:0] SUN_X = 20'sd77;
  localparam logic signed [19:0] SUN_Y = 20'sd128;
  localparam logic signed [19:0] SUN_Z = 20'sd205;

  localparam logic [6:0] LIMIT_RESET = 7'd32;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         slot_index;
    logic [6:0]         active_limit;
    logic signed [19:0] coord_x;
    logic signed [19:0] coord_y;
    logic signed [19:0] coord_z;
    logic [18:0]        radius;
    logic [31:0]        color_rgba;
    logic [15:0]        intensity;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         entry_slot;
    logic               light_kind;
    logic               light_on;
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic signed [19:0] out_z;
    logic [18:0]        out_radius;
    logic [31:0]        out_color;
    logic [15:0]        out_intensity;
    logic [6:0]         enabled_total;
    logic               last;
  } out_t;

  typedef struct packed {
    logic               kind;
    logic               on;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [18:0]        radius;
    logic [31:0]        color;
    logic [15:0]        intensity;
  } entry_t;

  typedef enum logic {RD_SQRT, RD_DIV} rd_mode_t;

  typedef struct packed {
    logic               start;
    rd_mode_t           mode;
    logic [SRC_W-1:0]   op_a;
    logic [ROOT_W-1:0]  divisor;
  } rd_req_t;

  typedef enum logic [3:0] {
    S_IDLE, S_NSQ, S_ROOT, S_DSTART, S_DIV, S_NWR, S_UPD,
    S_DRD, S_DIST, S_SCAN, S_PICK, S_MOVE, S_SUNRD, S_SUN
  } state_t;

endpackage

`default_nettype wire

/* design/nlct_root_div.sv */
// Bit-serial square root and restoring divider sharing one compare-subtract.
`default_nettype none

module nlct_root_div import nlct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  rd_req_t              req,
  output logic                 done,
  output logic [NUMER_W-1:0]   res
);

  logic [SRC_W-1:0]  src;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] divisor;
  logic [5:0]        cnt;
  logic              active;
  rd_mode_t          mode;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;
  logic              ge;
  logic [REM_W-1:0]  rem_next;
  logic [SRC_W-1:0]  src_next;

  always_comb begin
    if (mode == RD_DIV) begin
      shifted  = {rem[REM_W-2:0], src[SRC_W-1]};
      trial    = REM_W'(divisor);
      src_next = {src[SRC_W-2:0], 1'b0};
    end else begin
      shifted  = {rem[REM_W-3:0], src[SRC_W-1:SRC_W-2]};
      trial    = {res[REM_W-3:0], 2'b01};
      src_next = {src[SRC_W-3:0], 2'b00};
    end
    ge       = shifted >= trial;
    rem_next = ge ? shifted - trial : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        src     <= req.op_a;
        divisor <= req.divisor;
        mode    <= req.mode;
        rem     <= '0;
        res     <= '0;
        cnt     <= (req.mode == RD_DIV) ? DIV_STEPS : SQRT_STEPS;
        active  <= 1'b1;
      end else if (active) begin
        src <= src_next;
        rem <= rem_next;
        res <= {res[NUMER_W-2:0], ge};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/nearest_light_cull_table_unit.sv */
// Light table with create, update, clear, nearest-first cull and sun lookup.
//
// One command word is taken when start is high and busy is low; busy stays
// high until the command's last result word has been driven. Results come
// one per strobe cycle and cannot be stalled. Point create, clear and
// invalid codes finish from idle; update passes through an update state.
// A directional create runs a normalize through the shared bit-serial
// root/divide unit: 28 root steps plus three 37-step divides. Cull runs a
// selection pass over the key memory for every output position; the sorted
// table goes to the other half of a ping-pong entry memory. Sun lookup
// scans the entries in slot order.
`default_nettype none

module nearest_light_cull_table_unit import nlct_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  in_t        item,
  input  logic       limit_we,
  input  logic [6:0] limit_wdata,
  output logic       strobe,
  output out_t       result
);

  localparam int IW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int AW         = IW + 1;
  localparam int MEM_DEPTH  = 2 ** AW;
  localparam int KEY_DEPTH  = 2 ** IW;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  function automatic logic signed [19:0] pick3(
    input logic signed [19:0] a, input logic signed [19:0] b,
    input logic signed [19:0] c, input logic [1:0] sel);
    case (sel)
      2'd0:    pick3 = a;
      2'd1:    pick3 = b;
      default: pick3 = c;
    endcase
  endfunction

  function automatic out_t entry_word(input entry_t e, input logic [5:0] slot,
                                      input logic [6:0] tot, input logic lst);
    out_t w;
    w.status        = ST_OK;
    w.entry_slot    = slot;
    w.light_kind    = e.kind;
    w.light_on      = e.on;
    w.out_x         = e.x;
    w.out_y         = e.y;
    w.out_z         = e.z;
    w.out_radius    = e.radius;
    w.out_color     = e.color;
    w.out_intensity = e.intensity;
    w.enabled_total = tot;
    w.last          = lst;
    return w;
  endfunction

  function automatic out_t blank_word(input logic [1:0] st, input logic [6:0] tot);
    out_t w;
    w               = '0;
    w.status        = st;
    w.enabled_total = tot;
    w.last          = 1'b1;
    return w;
  endfunction

  state_t state, state_next;
  in_t    in_r, in_next;

  logic [CNT_W-1:0] light_limit;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] en, en_next;
  logic             bank, bank_next;
  logic [IW-1:0]    ptr, ptr_next;
  logic [IW-1:0]    pos, pos_next;
  logic [1:0]       k, k_next;
  logic [ACC_W-1:0] acc, acc_next;
  logic [ROOT_W-1:0] root_r, root_next;
  logic [2:0][19:0] norm, norm_next;
  logic [CNT_W-1:0] j, j_next;
  logic [IW-1:0]    jd, jd_next;
  logic             vld, vld_next;
  logic             have_best, have_best_next;
  logic [IW-1:0]    best, best_next;
  logic [KEY_W-1:0] best_key, best_key_next;
  logic [TABLE_DEPTH-1:0] picked, picked_next;

  logic             out_load;
  out_t             out_next;

  entry_t           mem [MEM_DEPTH];
  entry_t           rd_q;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  entry_t           mem_wd;

  logic [KEY_W-1:0] key_mem [KEY_DEPTH];
  logic [KEY_W-1:0] key_q;
  logic             key_we;
  logic [KEY_W-1:0] key_wd;

  logic signed [20:0] sq_in;
  logic [SQ_W-1:0]    prod;

  rd_req_t            rd_req;
  logic               rd_done;
  logic [NUMER_W-1:0] rd_res;

  logic [CNT_W-1:0]   cap;
  logic [CNT_W-1:0]   cull_en;
  logic [IW-1:0]      idle_slot;
  logic signed [19:0] in_c;
  logic signed [19:0] ent_c;
  logic [19:0]        mag;
  logic [NUMER_W-1:0] numer;
  logic [19:0]        qv;
  logic [19:0]        normv;
  logic               cand;
  entry_t             e;

  nlct_root_div u_root_div (
    .clk  (clk),
    .rst  (rst),
    .req  (rd_req),
    .done (rd_done),
    .res  (rd_res)
  );

  assign busy      = (state != S_IDLE);
  assign cap       = (light_limit < DEPTH_CNT) ? light_limit : DEPTH_CNT;
  assign cull_en   = (in_r.active_limit < count) ? in_r.active_limit : count;
  assign idle_slot = item.slot_index[IW-1:0];
  assign rd_addr   = {bank, (state == S_IDLE) ? idle_slot : ptr};
  assign in_c      = pick3(in_r.coord_x, in_r.coord_y, in_r.coord_z, k);
  assign ent_c     = pick3(rd_q.x, rd_q.y, rd_q.z, k);
  assign mag       = in_c[19] ? 20'(-in_c) : 20'(in_c);
  assign numer     = {1'b0, mag, 16'b0} + NUMER_W'(root_r >> 1);
  assign qv        = {11'b0, rd_res[8:0]};
  assign normv     = in_c[19] ? 20'(-qv) : qv;
  assign cand      = vld && !picked[jd] && (!have_best || key_q < best_key);

  always_comb begin
    state_next     = state;
    in_next        = in_r;
    count_next     = count;
    en_next        = en;
    bank_next      = bank;
    ptr_next       = ptr;
    pos_next       = pos;
    k_next         = k;
    acc_next       = acc;
    root_next      = root_r;
    norm_next      = norm;
    j_next         = j;
    jd_next        = jd;
    vld_next       = vld;
    have_best_next = have_best;
    best_next      = best;
    best_key_next  = best_key;
    picked_next    = picked;
    out_load       = 1'b0;
    out_next       = '0;
    mem_we         = 1'b0;
    mem_wa         = {bank, count[IW-1:0]};
    mem_wd         = '0;
    key_we         = 1'b0;
    key_wd         = '0;
    sq_in          = '0;
    rd_req         = '0;
    e              = rd_q;

    case (state)
      S_IDLE: begin
        if (start) begin
          in_next  = item;
          ptr_next = idle_slot;
          k_next   = 2'd0;
          case (item.command)
            CMD_POINT, CMD_DIR: begin
              if (count >= cap) begin
                out_load = 1'b1;
                out_next = blank_word(ST_FULL, en);
              end else if (item.command == CMD_POINT) begin
                mem_we       = 1'b1;
                mem_wd.kind  = 1'b0;
                mem_wd.on    = 1'b1;
                mem_wd.x     = item.coord_x;
                mem_wd.y     = item.coord_y;
                mem_wd.z     = item.coord_z;
                mem_wd.radius    = item.radius;
                mem_wd.color     = item.color_rgba;
                mem_wd.intensity = item.intensity;
                count_next = count + 7'd1;
                en_next    = en + 7'd1;
                out_load   = 1'b1;
                out_next   = entry_word(mem_wd, 6'(count), en_next, 1'b1);
              end else begin
                state_next = S_NSQ;
              end
            end
            CMD_UPDATE: begin
              if (7'(item.slot_index) >= count) begin
                out_load = 1'b1;
                out_next = blank_word(ST_BAD, en);
              end else begin
                state_next = S_UPD;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
              en_next    = '0;
              out_load   = 1'b1;
              out_next   = blank_word(ST_OK, 7'd0);
            end
            CMD_CULL: begin
              if (count != '0) begin
                ptr_next    = '0;
                pos_next    = '0;
                picked_next = '0;
                state_next  = S_DRD;
              end
            end
            CMD_SUN: begin
              if (count == '0) begin
                out_load = 1'b1;
                out_next = blank_word(ST_OK, en);
                out_next.light_kind = 1'b1;
                out_next.out_x = SUN_X;
                out_next.out_y = SUN_Y;
                out_next.out_z = SUN_Z;
              end else begin
                ptr_next   = '0;
                state_next = S_SUNRD;
              end
            end
            default: ;
          endcase
        end
      end

      // sum of squares of the direction, one component a cycle
      S_NSQ: begin
        sq_in    = {in_c[19], in_c};
        acc_next = (k == 2'd0) ? '0 : acc + ACC_W'(prod);
        k_next   = k + 2'd1;
        if (k == 2'd3) begin
          if (acc_next == '0) begin
            norm_next  = '0;
            state_next = S_NWR;
          end else begin
            rd_req.start = 1'b1;
            rd_req.mode  = RD_SQRT;
            rd_req.op_a  = {acc_next[39:0], 16'b0};
            state_next   = S_ROOT;
          end
        end
      end

      S_ROOT: begin
        if (rd_done) begin
          root_next  = rd_res[ROOT_W-1:0];
          k_next     = 2'd0;
          state_next = S_DSTART;
        end
      end

      S_DSTART: begin
        rd_req.start   = 1'b1;
        rd_req.mode    = RD_DIV;
        rd_req.op_a    = {numer, {(SRC_W-NUMER_W){1'b0}}};
        rd_req.divisor = root_r;
        state_next     = S_DIV;
      end

      S_DIV: begin
        if (rd_done) begin
          norm_next[k] = normv;
          if (k == 2'd2) begin
            state_next = S_NWR;
          end else begin
            k_next     = k + 2'd1;
            state_next = S_DSTART;
          end
        end
      end

      S_NWR: begin
        mem_we           = 1'b1;
        mem_wd.kind      = 1'b1;
        mem_wd.on        = 1'b1;
        mem_wd.x         = norm[0];
        mem_wd.y         = norm[1];
        mem_wd.z         = norm[2];
        mem_wd.radius    = '0;
        mem_wd.color     = in_r.color_rgba;
        mem_wd.intensity = in_r.intensity;
        count_next = count + 7'd1;
        en_next    = en + 7'd1;
        out_load   = 1'b1;
        out_next   = entry_word(mem_wd, 6'(count), en_next, 1'b1);
        state_next = S_IDLE;
      end

      // keep kind, radius and enable; replace the rest
      S_UPD: begin
        e.x         = in_r.coord_x;
        e.y         = in_r.coord_y;
        e.z         = in_r.coord_z;
        e.color     = in_r.color_rgba;
        e.intensity = in_r.intensity;
        mem_we      = 1'b1;
        mem_wa      = {bank, ptr};
        mem_wd      = e;
        out_load    = 1'b1;
        out_next    = entry_word(e, 6'(ptr), en, 1'b1);
        state_next  = S_IDLE;
      end

      S_DRD: begin
        k_next     = 2'd0;
        state_next = S_DIST;
      end

      // squared distance to the camera; point lights sort after directional
      S_DIST: begin
        sq_in    = {ent_c[19], ent_c} - {in_c[19], in_c};
        acc_next = (k == 2'd0) ? '0 : acc + ACC_W'(prod);
        k_next   = k + 2'd1;
        if (k == 2'd3) begin
          key_we = 1'b1;
          key_wd = {~rd_q.kind, acc_next};
          if (7'(ptr) == count - 7'd1) begin
            j_next         = '0;
            vld_next       = 1'b0;
            have_best_next = 1'b0;
            state_next     = S_SCAN;
          end else begin
            ptr_next   = ptr + 1'b1;
            state_next = S_DRD;
          end
        end
      end

      // strict less-than over ascending slots keeps the sort stable
      S_SCAN: begin
        if (cand) begin
          best_next      = jd;
          best_key_next  = key_q;
          have_best_next = 1'b1;
        end
        if (j == count) begin
          ptr_next   = best_next;
          state_next = S_PICK;
        end else begin
          jd_next  = j[IW-1:0];
          vld_next = 1'b1;
          j_next   = j + 7'd1;
        end
      end

      S_PICK: begin
        state_next = S_MOVE;
      end

      S_MOVE: begin
        e.on     = 7'(pos) < in_r.active_limit;
        mem_we   = 1'b1;
        mem_wa   = {~bank, pos};
        mem_wd   = e;
        out_load = 1'b1;
        out_next = entry_word(e, 6'(pos), cull_en, 7'(pos) == count - 7'd1);
        picked_next[ptr] = 1'b1;
        if (7'(pos) == count - 7'd1) begin
          bank_next  = ~bank;
          en_next    = cull_en;
          state_next = S_IDLE;
        end else begin
          pos_next       = pos + 1'b1;
          j_next         = '0;
          vld_next       = 1'b0;
          have_best_next = 1'b0;
          state_next     = S_SCAN;
        end
      end

      S_SUNRD: begin
        state_next = S_SUN;
      end

      S_SUN: begin
        if (rd_q.kind && rd_q.on) begin
          out_load   = 1'b1;
          out_next   = entry_word(rd_q, 6'(ptr), en, 1'b1);
          state_next = S_IDLE;
        end else if (7'(ptr) == count - 7'd1) begin
          out_load = 1'b1;
          out_next = blank_word(ST_OK, en);
          out_next.light_kind = 1'b1;
          out_next.out_x = SUN_X;
          out_next.out_y = SUN_Y;
          out_next.out_z = SUN_Z;
          state_next = S_IDLE;
        end else begin
          ptr_next   = ptr + 1'b1;
          state_next = S_SUNRD;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_limit <= LIMIT_RESET;
      count       <= '0;
      en          <= '0;
      bank        <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      if (limit_we) begin
        light_limit <= limit_wdata;
      end
      count  <= count_next;
      en     <= en_next;
      bank   <= bank_next;
      strobe <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_next;
    ptr       <= ptr_next;
    pos       <= pos_next;
    k         <= k_next;
    acc       <= acc_next;
    root_r    <= root_next;
    norm      <= norm_next;
    j         <= j_next;
    jd        <= jd_next;
    vld       <= vld_next;
    have_best <= have_best_next;
    best      <= best_next;
    best_key  <= best_key_next;
    picked    <= picked_next;
    prod      <= SQ_W'(sq_in * sq_in);
    if (out_load) begin
      result <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[ptr] <= key_wd;
    end
    key_q <= key_mem[j[IW-1:0]];
  end

endmodule

`default_nettype wire
